// ===== hdl/tal_pkg.sv =====
// shared types, constants and microprogram layout for the ancestor engine
`default_nettype none
package tal_pkg;

  localparam int NODE_W  = 10;
  localparam int DEPTH_W = 10;
  localparam int LEN_W   = 11;
  localparam int LEVELS  = 10;
  localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CNT_W   = $clog2(LEVELS + 1);
  localparam int JADDR_W = NODE_W + LVL_W;
  localparam int JDEPTH  = 2 ** JADDR_W;
  localparam int DDEPTH  = 2 ** NODE_W;
  localparam int PC_W    = 5;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

  typedef enum logic [4:0] {
    UOP_ACCEPT,
    UOP_ADD_INIT,
    UOP_ADD_DEPTH,
    UOP_ROW_READ,
    UOP_ROW_WRITE,
    UOP_EMIT,
    UOP_Q_DEPTH,
    UOP_Q_ORDER,
    UOP_LIFT_READ,
    UOP_LIFT_TAKE,
    UOP_LEVEL_DOWN,
    UOP_BOTH_INIT,
    UOP_BOTH_READ,
    UOP_BOTH_STEP,
    UOP_FINAL_READ,
    UOP_FINAL_TAKE,
    UOP_C_DEPTH,
    UOP_C_LEN
  } uop_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_BEAT,
    STALL_OUT
  } stall_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_IN_QUERY,
    COND_ROW_DONE,
    COND_ROW_MORE,
    COND_GAP_CLEAR,
    COND_LEVEL_LEFT,
    COND_SAME_NODE
  } cond_t;

  typedef struct packed {
    uop_t            uop;
    stall_t          stall;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    uop_t uop;
    logic go;
  } ctrl_t;

  typedef struct packed {
    logic beat_in;
    logic in_query;
    logic out_free;
    logic row_done;
    logic row_more;
    logic gap_clear;
    logic level_left;
    logic same_node;
  } status_t;

  localparam logic [PC_W-1:0] STEP_IDLE       = 5'd0;
  localparam logic [PC_W-1:0] STEP_ADD_INIT   = 5'd1;
  localparam logic [PC_W-1:0] STEP_ADD_DEPTH  = 5'd2;
  localparam logic [PC_W-1:0] STEP_ROW_READ   = 5'd3;
  localparam logic [PC_W-1:0] STEP_ROW_WRITE  = 5'd4;
  localparam logic [PC_W-1:0] STEP_FINISH     = 5'd5;
  localparam logic [PC_W-1:0] STEP_Q_DEPTH    = 5'd6;
  localparam logic [PC_W-1:0] STEP_Q_ORDER    = 5'd7;
  localparam logic [PC_W-1:0] STEP_LIFT_READ  = 5'd8;
  localparam logic [PC_W-1:0] STEP_LIFT_TAKE  = 5'd9;
  localparam logic [PC_W-1:0] STEP_LEVEL_DOWN = 5'd10;
  localparam logic [PC_W-1:0] STEP_BOTH_INIT  = 5'd11;
  localparam logic [PC_W-1:0] STEP_BOTH_READ  = 5'd12;
  localparam logic [PC_W-1:0] STEP_BOTH_STEP  = 5'd13;
  localparam logic [PC_W-1:0] STEP_FINAL_READ = 5'd14;
  localparam logic [PC_W-1:0] STEP_FINAL_TAKE = 5'd15;
  localparam logic [PC_W-1:0] STEP_C_DEPTH    = 5'd16;
  localparam logic [PC_W-1:0] STEP_C_LEN      = 5'd17;

endpackage
`default_nettype wire

// ===== hdl/tree_ancestor_lca_engine_unit.sv =====
// top level of the binary-lifting ancestor and distance engine
// add beat: the result follows one jump-table read and write per level
// query beat: the lift loops run on dependent jump-table reads
// one beat at a time; next beat taken while the result waits in the output register
// reset clears the step counter and output valid only; tables hold nothing until written
`default_nettype none
module tree_ancestor_lca_engine_unit import tal_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,  // node_a, node_b, zero pad
  input  wire logic        s_tuser,  // opcode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [23:0] m_tdata   // ancestor_node, path_length, zero pad
);

  ctrl_t   ctrl;
  status_t status;

  tal_useq u_useq (
    .clk   (clk),
    .rst   (rst),
    .status(status),
    .ctrl  (ctrl)
  );

  tal_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .status  (status),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("sequencer stayed idle after an input beat");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    ctrl.uop == UOP_EMIT && ctrl.go |=> m_tvalid)
    else $error("emitted result not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.uop == UOP_EMIT && ctrl.go |-> !m_tvalid || m_tready)
    else $error("waiting result overwritten");

endmodule
`default_nettype wire

// ===== hdl/tal_ram.sv =====
// generic ram, one write port, two registered read ports
`default_nettype none
module tal_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1,
  output logic      [WIDTH-1:0]         rdata0,
  output logic      [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule
`default_nettype wire

// ===== hdl/tal_useq.sv =====
// microprogram rom, step counter and jump logic
`default_nettype none
module tal_useq import tal_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire status_t status,
  output ctrl_t        ctrl
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ucode_t          word;
  logic            hold;
  logic            taken;

  function automatic ucode_t rom(input logic [PC_W-1:0] step);
    ucode_t w;
    unique case (step)
      STEP_IDLE:       w = '{UOP_ACCEPT,     STALL_BEAT, COND_IN_QUERY,   STEP_Q_DEPTH};
      STEP_ADD_INIT:   w = '{UOP_ADD_INIT,   STALL_NONE, COND_NEVER,      STEP_IDLE};
      STEP_ADD_DEPTH:  w = '{UOP_ADD_DEPTH,  STALL_NONE, COND_ROW_DONE,   STEP_FINISH};
      STEP_ROW_READ:   w = '{UOP_ROW_READ,   STALL_NONE, COND_NEVER,      STEP_IDLE};
      STEP_ROW_WRITE:  w = '{UOP_ROW_WRITE,  STALL_NONE, COND_ROW_MORE,   STEP_ROW_READ};
      STEP_FINISH:     w = '{UOP_EMIT,       STALL_OUT,  COND_ALWAYS,     STEP_IDLE};
      STEP_Q_DEPTH:    w = '{UOP_Q_DEPTH,    STALL_NONE, COND_NEVER,      STEP_IDLE};
      STEP_Q_ORDER:    w = '{UOP_Q_ORDER,    STALL_NONE, COND_NEVER,      STEP_IDLE};
      STEP_LIFT_READ:  w = '{UOP_LIFT_READ,  STALL_NONE, COND_GAP_CLEAR,  STEP_LEVEL_DOWN};
      STEP_LIFT_TAKE:  w = '{UOP_LIFT_TAKE,  STALL_NONE, COND_NEVER,      STEP_IDLE};
      STEP_LEVEL_DOWN: w = '{UOP_LEVEL_DOWN, STALL_NONE, COND_LEVEL_LEFT, STEP_LIFT_READ};
      STEP_BOTH_INIT:  w = '{UOP_BOTH_INIT,  STALL_NONE, COND_SAME_NODE,  STEP_C_DEPTH};
      STEP_BOTH_READ:  w = '{UOP_BOTH_READ,  STALL_NONE, COND_NEVER,      STEP_IDLE};
      STEP_BOTH_STEP:  w = '{UOP_BOTH_STEP,  STALL_NONE, COND_LEVEL_LEFT, STEP_BOTH_READ};
      STEP_FINAL_READ: w = '{UOP_FINAL_READ, STALL_NONE, COND_NEVER,      STEP_IDLE};
      STEP_FINAL_TAKE: w = '{UOP_FINAL_TAKE, STALL_NONE, COND_NEVER,      STEP_IDLE};
      STEP_C_DEPTH:    w = '{UOP_C_DEPTH,    STALL_NONE, COND_NEVER,      STEP_IDLE};
      STEP_C_LEN:      w = '{UOP_C_LEN,      STALL_NONE, COND_ALWAYS,     STEP_FINISH};
      default:         w = '{UOP_EMIT,       STALL_NONE, COND_ALWAYS,     STEP_IDLE};
    endcase
    return w;
  endfunction

  assign word = rom(pc);

  always_comb begin
    unique case (word.stall)
      STALL_BEAT: hold = !status.beat_in;
      STALL_OUT:  hold = !status.out_free;
      default:    hold = 1'b0;
    endcase
  end

  always_comb begin
    unique case (word.cond)
      COND_ALWAYS:     taken = 1'b1;
      COND_IN_QUERY:   taken = status.in_query;
      COND_ROW_DONE:   taken = status.row_done;
      COND_ROW_MORE:   taken = status.row_more;
      COND_GAP_CLEAR:  taken = status.gap_clear;
      COND_LEVEL_LEFT: taken = status.level_left;
      COND_SAME_NODE:  taken = status.same_node;
      default:         taken = 1'b0;
    endcase
  end

  always_comb begin
    if (hold) begin
      pc_next = pc;
    end else if (taken) begin
      pc_next = word.target;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign ctrl.uop = word.uop;
  assign ctrl.go  = !hold;

endmodule
`default_nettype wire

// ===== hdl/tal_datapath.sv =====
// node and level registers, depth and jump tables, result register
`default_nettype none
module tal_datapath import tal_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ctrl_t       ctrl,
  output status_t          status,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,
  input  wire logic        s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [23:0] m_tdata
);

  logic [NODE_W-1:0]  node_x;
  logic [NODE_W-1:0]  node_y;
  logic [CNT_W-1:0]   level;
  logic [LEVELS-1:0]  gap;
  logic [LEN_W-1:0]   depth_sum;
  logic [NODE_W-1:0]  res_node;
  logic [LEN_W-1:0]   res_len;

  logic [LVL_W-1:0]   lvl;
  logic [CNT_W-1:0]   level_prev;
  logic               emit;

  logic               j_we;
  logic [JADDR_W-1:0] j_waddr;
  logic [NODE_W-1:0]  j_wdata;
  logic [JADDR_W-1:0] j_raddr0;
  logic [JADDR_W-1:0] j_raddr1;
  logic [NODE_W-1:0]  j_rdata0;
  logic [NODE_W-1:0]  j_rdata1;

  logic               d_we;
  logic [NODE_W-1:0]  d_raddr0;
  logic [DEPTH_W-1:0] d_wdata;
  logic [DEPTH_W-1:0] d_rdata0;
  logic [DEPTH_W-1:0] d_rdata1;

  logic [LEN_W-1:0]   twice;

  assign lvl        = level[LVL_W-1:0];
  assign level_prev = level - CNT_W'(1);
  assign s_tready   = (ctrl.uop == UOP_ACCEPT);
  assign emit       = (ctrl.uop == UOP_EMIT) && ctrl.go;
  assign twice      = {d_rdata0, 1'b0};

  // saturating child depth, root stays at zero
  always_comb begin
    if (node_x == node_y) begin
      d_wdata = '0;
    end else if (d_rdata0 == DEPTH_MAX) begin
      d_wdata = DEPTH_MAX;
    end else begin
      d_wdata = d_rdata0 + DEPTH_W'(1);
    end
  end

  always_comb begin
    j_we     = 1'b0;
    j_waddr  = {node_x, lvl};
    j_wdata  = j_rdata0;
    j_raddr0 = {node_x, lvl};
    j_raddr1 = {node_y, lvl};
    d_we     = 1'b0;
    d_raddr0 = node_x;
    unique case (ctrl.uop)
      UOP_ADD_INIT: begin
        j_we     = 1'b1;
        j_waddr  = {node_x, LVL_W'(0)};
        j_wdata  = node_y;
        d_raddr0 = node_y;
      end
      UOP_ADD_DEPTH: begin
        d_we = 1'b1;
      end
      UOP_ROW_READ: begin
        j_raddr0 = {node_y, level_prev[LVL_W-1:0]};
      end
      UOP_ROW_WRITE: begin
        j_we = 1'b1;
      end
      UOP_FINAL_READ: begin
        j_raddr0 = {node_x, LVL_W'(0)};
      end
      default: begin
      end
    endcase
  end

  tal_ram #(
    .WIDTH(NODE_W),
    .DEPTH(JDEPTH)
  ) u_jump (
    .clk   (clk),
    .we    (j_we),
    .waddr (j_waddr),
    .wdata (j_wdata),
    .raddr0(j_raddr0),
    .raddr1(j_raddr1),
    .rdata0(j_rdata0),
    .rdata1(j_rdata1)
  );

  tal_ram #(
    .WIDTH(DEPTH_W),
    .DEPTH(DDEPTH)
  ) u_depth (
    .clk   (clk),
    .we    (d_we),
    .waddr (node_x),
    .wdata (d_wdata),
    .raddr0(d_raddr0),
    .raddr1(node_y),
    .rdata0(d_rdata0),
    .rdata1(d_rdata1)
  );

  always_ff @(posedge clk) begin
    unique case (ctrl.uop)
      UOP_ACCEPT: begin
        if (ctrl.go) begin
          node_x <= s_tdata[NODE_W-1:0];
          node_y <= s_tdata[2*NODE_W-1:NODE_W];
        end
      end
      UOP_ADD_INIT: begin
        level <= CNT_W'(1);
      end
      UOP_ADD_DEPTH: begin
        res_node <= node_x;
        res_len  <= {1'b0, d_wdata};
      end
      UOP_ROW_WRITE: begin
        node_y <= j_rdata0;
        level  <= level + CNT_W'(1);
      end
      UOP_Q_ORDER: begin
        depth_sum <= {1'b0, d_rdata0} + {1'b0, d_rdata1};
        level     <= CNT_W'(LEVELS - 1);
        if (d_rdata0 < d_rdata1) begin
          node_x <= node_y;
          node_y <= node_x;
          gap    <= LEVELS'(d_rdata1 - d_rdata0);
        end else begin
          gap    <= LEVELS'(d_rdata0 - d_rdata1);
        end
      end
      UOP_LIFT_TAKE: begin
        node_x <= j_rdata0;
      end
      UOP_LEVEL_DOWN: begin
        level <= level_prev;
      end
      UOP_BOTH_INIT: begin
        level <= CNT_W'(LEVELS - 1);
      end
      UOP_BOTH_STEP: begin
        level <= level_prev;
        if (j_rdata0 != j_rdata1) begin
          node_x <= j_rdata0;
          node_y <= j_rdata1;
        end
      end
      UOP_FINAL_TAKE: begin
        node_x <= j_rdata0;
      end
      UOP_C_LEN: begin
        res_node <= node_x;
        res_len  <= (depth_sum >= twice) ? depth_sum - twice : '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {3'b000, res_len, res_node};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign status.beat_in    = s_tvalid;
  assign status.in_query   = s_tuser;
  assign status.out_free   = !m_tvalid || m_tready;
  assign status.row_done   = (level == CNT_W'(LEVELS));
  assign status.row_more   = (level != CNT_W'(LEVELS - 1));
  assign status.gap_clear  = !gap[lvl];
  assign status.level_left = (level != '0);
  assign status.same_node  = (node_x == node_y);

endmodule
`default_nettype wire
